>>> rtl/core/mbrc_pkg.sv
// ----------------------------------------------------------------------------
// mbrc_pkg: shared types and constants of the read-response checker
// Holds the status codes, sequencer states, frame constants and the
// byte-wise CRC-16 update used by the checker core.
// ----------------------------------------------------------------------------
package mbrc_pkg;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam int unsigned EXC_BIT         = 7;
  localparam logic [7:0]  MIN_FRAME       = 8'd5;

  // Configuration register indexes
  localparam logic CFG_EXPECTED_ADDRESS = 1'b0;
  localparam logic CFG_EXPECTED_COUNT   = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_CRC       = 3'd2,
    ST_ADDRESS   = 3'd3,
    ST_EXCEPTION = 3'd4,
    ST_FUNCTION  = 3'd5,
    ST_BYTECOUNT = 3'd6,
    ST_LENGTH    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_COLLECT,
    S_READ,
    S_WORD,
    S_STATUS
  } state_t;

  // Fold one byte into a reflected CRC-16, one bit per step
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/modbus_read_response_checker_core.sv
// ----------------------------------------------------------------------------
// modbus_read_response_checker_core: read-holding-registers reply checker
// Collects a reply one byte per cycle while no result is pending, keeps a
// running CRC-16, stores the register words in an on-chip buffer, checks the
// frame at its end and emits the words of an ok frame, then a status item.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle while a frame is collected.
// A status item with no words before it is valid in the cycle after the
// end-of-frame byte is taken. Each word is first read from the buffer (S_READ),
// then output (S_WORD), so an ok frame holds off input until its words and
// status item are all taken, output stalls included.
// Reset: clears frame state and config to defaults; the word buffer is not cleared.
module modbus_read_response_checker_core
  import mbrc_pkg::*;
#(
  parameter int MAX_REGS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_register,
  output logic [4:0]  out_reg_index,
  output logic [15:0] out_reg_value,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic        out_last
);

  // Buffer address width; word positions in a frame never exceed 7 bits
  localparam int AW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  // Word buffer: one write port (collect), one registered read port (drain)
  logic [15:0] mem [MAX_REGS];
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [15:0] rd_data_r;

  // Configuration
  logic [7:0] exp_addr_r;
  logic [5:0] exp_count_r;

  // Frame state
  logic [7:0]  pos_r,   pos_nxt;
  logic [15:0] crc_r,   crc_nxt;
  logic [7:0]  addr_r,  addr_nxt;
  logic [7:0]  func_r,  func_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  hold_r,  hold_nxt;

  // End-of-frame result and drain sequencer
  status_t     st_r, st_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic [5:0]  idx_r, idx_nxt;
  state_t      state_r, state_nxt;

  logic        in_acc;
  logic        out_acc;
  logic [15:0] crc_upd;
  logic [7:0]  pos_inc;
  logic [7:0]  pos_m3;
  logic [6:0]  word_pos;
  logic [7:0]  addr_cur, func_cur, count_cur;
  logic [7:0]  idx_wide;
  logic [6:0]  idx_plus;
  status_t     st_calc;
  logic [7:0]  exc_calc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Per-byte datapath
  assign crc_upd  = crc16_byte(crc_r, in_rx_byte);
  assign pos_inc  = (pos_r == 8'hFF) ? pos_r : pos_r + 8'd1;
  assign pos_m3   = pos_r - 8'd3;
  assign word_pos = pos_m3[7:1];

  // Header bytes as they stand after this byte (bypass the current byte)
  assign addr_cur  = (pos_r == 8'd0) ? in_rx_byte : addr_r;
  assign func_cur  = (pos_r == 8'd1) ? in_rx_byte : func_r;
  assign count_cur = (pos_r == 8'd2) ? in_rx_byte : count_r;

  // Store the low byte of a word together with its held high byte
  assign mem_we    = in_acc && (pos_r >= 8'd3) && !pos_r[0] &&
                     (word_pos < 7'(MAX_REGS));
  assign mem_waddr = word_pos[AW-1:0];

  assign idx_wide  = {2'b00, idx_r};
  assign mem_raddr = idx_wide[AW-1:0];
  assign idx_plus  = {1'b0, idx_r} + 7'd1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= {hold_r, in_rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Frame checks in priority order
  always_comb begin
    exc_calc = 8'h00;
    if (pos_inc < MIN_FRAME) begin
      st_calc = ST_SHORT;
    end else if (crc_upd != 16'h0000) begin
      st_calc = ST_CRC;
    end else if (addr_cur != exp_addr_r) begin
      st_calc = ST_ADDRESS;
    end else if (func_cur[EXC_BIT]) begin
      st_calc  = ST_EXCEPTION;
      exc_calc = count_cur;
    end else if (func_cur != FN_READ_HOLDING) begin
      st_calc = ST_FUNCTION;
    end else if ({1'b0, count_cur} != {2'b00, exp_count_r, 1'b0}) begin
      st_calc = ST_BYTECOUNT;
    end else if (pos_inc != MIN_FRAME + {1'b0, exp_count_r, 1'b0}) begin
      st_calc = ST_LENGTH;
    end else if ({1'b0, exp_count_r} > 7'(MAX_REGS)) begin
      st_calc = ST_LENGTH;
    end else begin
      st_calc = ST_OK;
    end
  end

  // Frame state update: advance on each byte, clear at end of frame
  always_comb begin
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    addr_nxt  = addr_r;
    func_nxt  = func_r;
    count_nxt = count_r;
    hold_nxt  = hold_r;
    st_nxt    = st_r;
    exc_nxt   = exc_r;
    if (in_acc) begin
      pos_nxt   = pos_inc;
      crc_nxt   = crc_upd;
      addr_nxt  = addr_cur;
      func_nxt  = func_cur;
      count_nxt = count_cur;
      if ((pos_r >= 8'd3) && pos_r[0]) begin
        hold_nxt = in_rx_byte;
      end
      if (in_end_of_frame) begin
        st_nxt    = st_calc;
        exc_nxt   = exc_calc;
        pos_nxt   = 8'd0;
        crc_nxt   = CRC_INIT;
        addr_nxt  = 8'd0;
        func_nxt  = 8'd0;
        count_nxt = 8'd0;
        hold_nxt  = 8'd0;
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    case (state_r)
      S_COLLECT: begin
        if (in_acc && in_end_of_frame) begin
          idx_nxt = 6'd0;
          if ((st_calc == ST_OK) && (exp_count_r != 6'd0)) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_READ: begin
        state_nxt = S_WORD;
      end
      S_WORD: begin
        if (out_acc) begin
          if (idx_plus < {1'b0, exp_count_r}) begin
            idx_nxt   = idx_plus[5:0];
            state_nxt = S_READ;
          end else begin
            state_nxt = S_STATUS;
          end
        end
      end
      S_STATUS: begin
        if (out_acc) begin
          state_nxt = S_COLLECT;
        end
      end
      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready           = 1'b0;
    out_valid          = 1'b0;
    out_is_register    = 1'b0;
    out_reg_index      = 5'd0;
    out_reg_value      = 16'h0000;
    out_status         = ST_OK;
    out_exception_code = 8'h00;
    out_last           = 1'b0;
    case (state_r)
      S_COLLECT: begin
        in_ready = 1'b1;
      end
      S_WORD: begin
        out_valid       = 1'b1;
        out_is_register = 1'b1;
        out_reg_index   = idx_r[4:0];
        out_reg_value   = rd_data_r;
      end
      S_STATUS: begin
        out_valid          = 1'b1;
        out_status         = st_r;
        out_exception_code = exc_r;
        out_last           = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= 8'd1;
      exp_count_r <= 6'd1;
      pos_r       <= 8'd0;
      crc_r       <= CRC_INIT;
      addr_r      <= 8'd0;
      func_r      <= 8'd0;
      count_r     <= 8'd0;
      hold_r      <= 8'd0;
      st_r        <= ST_OK;
      exc_r       <= 8'h00;
      idx_r       <= 6'd0;
      state_r     <= S_COLLECT;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXPECTED_ADDRESS: exp_addr_r  <= cfg_data;
          CFG_EXPECTED_COUNT:   exp_count_r <= cfg_data[5:0];
          default:              exp_addr_r  <= exp_addr_r;
        endcase
      end
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      addr_r  <= addr_nxt;
      func_r  <= func_nxt;
      count_r <= count_nxt;
      hold_r  <= hold_nxt;
      st_r    <= st_nxt;
      exc_r   <= exc_nxt;
      idx_r   <= idx_nxt;
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_in_out_mutex: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WORD) |-> (idx_r < exp_count_r))
    else $error("register word index beyond expected count");

  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_frame) |=> ((pos_r == 8'd0) && (crc_r == CRC_INIT)))
    else $error("frame state not cleared after end of frame");

  a_words_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WORD) |-> (st_r == ST_OK))
    else $error("register word emitted for a failed frame");

  a_status_returns: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> in_ready)
    else $error("collector not re-armed after status item");
`endif

endmodule

>>> tb/mbrc_reply_checker.sv
// ----------------------------------------------------------------------------
// mbrc_reply_checker: result predictor and comparator for the reply checker
// Watches the configuration port and both item channels, rebuilds the
// frame state byte by byte, queues the words and status it expects at each
// end of frame and compares every accepted result against them.
// ----------------------------------------------------------------------------
package mbrc_tb_pkg;

  import mbrc_pkg::*;

  // Bit-serial form of the reflected CRC-16, least significant bit first
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc,
                                             input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ data[i];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

endpackage

module mbrc_reply_checker
  import mbrc_pkg::*;
  import mbrc_tb_pkg::*;
#(
  parameter int MAX_REGS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_end_of_frame,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_is_register,
  input  logic [4:0]  out_reg_index,
  input  logic [15:0] out_reg_value,
  input  logic [2:0]  out_status,
  input  logic [7:0]  out_exception_code,
  input  logic        out_last,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic        is_reg;
    logic [4:0]  idx;
    logic [15:0] value;
    status_t     status;
    logic [7:0]  exc_code;
    logic        last;
  } reply_t;

  reply_t      awaited_q[$];
  logic [7:0]  want_addr;
  logic [5:0]  want_count;
  logic [7:0]  pos;
  logic [15:0] crc_acc;
  logic [7:0]  addr_b;
  logic [7:0]  func_b;
  logic [7:0]  count_b;
  logic [7:0]  hi_b;
  logic [15:0] words [MAX_REGS];
  int          errs = 0;

  task automatic clear_frame_state();
    pos     = '0;
    crc_acc = CRC_INIT;
    addr_b  = '0;
    func_b  = '0;
    count_b = '0;
    hi_b    = '0;
  endtask

  // Append one expected result at the tail of the queue
  task automatic queue_reply(input reply_t r);
    awaited_q.insert(awaited_q.size(), r);
  endtask

  // Fold one byte into the frame state; at end of frame queue the results
  task automatic absorb_byte(input logic [7:0] b, input logic eof);
    int         w;
    int         len;
    status_t    verdict;
    logic [7:0] code;
    reply_t     r;
    crc_acc = crc16_fold(crc_acc, b);
    if (pos == 8'd0) begin
      addr_b = b;
    end else if (pos == 8'd1) begin
      func_b = b;
    end else if (pos == 8'd2) begin
      count_b = b;
    end else if (pos[0]) begin
      hi_b = b;
    end else begin
      w = (int'(pos) - 4) / 2;
      if (w < MAX_REGS) begin
        words[w] = {hi_b, b};
      end
    end
    if (pos != 8'd255) begin
      pos = pos + 8'd1;
    end
    if (!eof) begin
      return;
    end

    len  = int'(pos);
    code = '0;
    if (len < int'(MIN_FRAME)) begin
      verdict = ST_SHORT;
    end else if (crc_acc != 16'd0) begin
      verdict = ST_CRC;
    end else if (addr_b != want_addr) begin
      verdict = ST_ADDRESS;
    end else if (func_b[EXC_BIT]) begin
      verdict = ST_EXCEPTION;
      code    = count_b;
    end else if (func_b != FN_READ_HOLDING) begin
      verdict = ST_FUNCTION;
    end else if (count_b != 8'(2 * int'(want_count))) begin
      verdict = ST_BYTECOUNT;
    end else if (len != int'(MIN_FRAME) + 2 * int'(want_count)) begin
      verdict = ST_LENGTH;
    end else if (int'(want_count) > MAX_REGS) begin
      verdict = ST_LENGTH;
    end else begin
      verdict = ST_OK;
    end

    if (verdict == ST_OK) begin
      for (int i = 0; i < int'(want_count); i++) begin
        r = '{is_reg: 1'b1, idx: 5'(i), value: words[i], status: ST_OK,
              exc_code: 8'd0, last: 1'b0};
        queue_reply(r);
      end
    end
    r = '{is_reg: 1'b0, idx: 5'd0, value: 16'd0, status: verdict,
          exc_code: code, last: 1'b1};
    queue_reply(r);
    clear_frame_state();
  endtask

  always @(posedge clk) begin : observe
    reply_t act;
    reply_t exp;
    if (!rst_n) begin
      want_addr  = 8'd1;
      want_count = 6'd1;
      clear_frame_state();
      awaited_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        act = '{is_reg: out_is_register, idx: out_reg_index, value: out_reg_value,
                status: status_t'(out_status), exc_code: out_exception_code,
                last: out_last};
        if (awaited_q.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("[%0t] unexpected result: reg=%0b idx=%0d val=%h st=%0d exc=%h last=%0b",
                     $realtime, act.is_reg, act.idx, act.value, act.status,
                     act.exc_code, act.last);
          end
        end else begin
          exp = awaited_q.pop_front();
          if (act !== exp) begin
            errs++;
            if (errs <= 10) begin
              $display("[%0t] result mismatch: exp reg=%0b idx=%0d val=%h st=%0d exc=%h last=%0b",
                       $realtime, exp.is_reg, exp.idx, exp.value, exp.status,
                       exp.exc_code, exp.last);
              $display("                       got reg=%0b idx=%0d val=%h st=%0d exc=%h last=%0b",
                       act.is_reg, act.idx, act.value, act.status, act.exc_code,
                       act.last);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_EXPECTED_ADDRESS) begin
          want_addr = cfg_data;
        end else begin
          want_count = cfg_data[5:0];
        end
      end
      if (in_valid && in_ready) begin
        absorb_byte(in_rx_byte, in_end_of_frame);
      end
    end
    mismatches  <= errs;
    outstanding <= awaited_q.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the read-response checker core
// Builds reply frames of every kind (good, short, bad CRC, wrong address,
// exception, wrong function, wrong byte count, wrong length, noise, long),
// sends them byte by byte in random bursts across several register settings,
// stalls the result side on its own pattern and lets the checker module
// predict and compare every result.
// ----------------------------------------------------------------------------
module tb;

  import mbrc_pkg::*;
  import mbrc_tb_pkg::*;

  localparam int MAX_REGS       = 32;
  localparam int NUM_ITEMS      = 280;   // minimum input items over the whole run
  localparam int HOLD_CYCLES    = 300;   // long result-side hold-off
  localparam int SETTLE_CYCLES  = 4;     // idle wait after the last expected result
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake and no config write

  typedef enum int {
    FR_GOOD,
    FR_SHORT,
    FR_BAD_CRC,
    FR_ADDR,
    FR_EXC,
    FR_FUNC,
    FR_BYTECOUNT,
    FR_LENGTH,
    FR_NOISE,
    FR_LONG
  } frame_kind_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        cfg_we          = 1'b0;
  logic        cfg_index       = CFG_EXPECTED_ADDRESS;
  logic [7:0]  cfg_data        = 8'd0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte      = 8'd0;
  logic        in_end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic        out_is_register;
  logic [4:0]  out_reg_index;
  logic [15:0] out_reg_value;
  logic [2:0]  out_status;
  logic [7:0]  out_exception_code;
  logic        out_last;
  int          mismatches;
  int          outstanding;

  logic [7:0]  frame_q[$];
  logic [7:0]  cur_addr;
  logic [5:0]  cur_count;
  int          burst_left    = 0;
  bit          offering      = 1'b0;
  int          bytes_sent    = 0;
  int          word_pattern  = 0;   // 0 random, 1 all zeros, 2 all ones
  int          hold_requests = 0;
  int          holds_served  = 0;

  modbus_read_response_checker_core #(
    .MAX_REGS(MAX_REGS)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_register   (out_is_register),
    .out_reg_index     (out_reg_index),
    .out_reg_value     (out_reg_value),
    .out_status        (out_status),
    .out_exception_code(out_exception_code),
    .out_last          (out_last)
  );

  mbrc_reply_checker #(
    .MAX_REGS(MAX_REGS)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .in_end_of_frame   (in_end_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_is_register   (out_is_register),
    .out_reg_index     (out_reg_index),
    .out_reg_value     (out_reg_value),
    .out_status        (out_status),
    .out_exception_code(out_exception_code),
    .out_last          (out_last),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: stall on one of four patterns, switching to a new random one
  // when its run ends; serve a long hold-off whenever the stimulus asks for one.
  initial begin : receiver
    int mode;
    int mode_left;
    int stall_left;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            out_ready <= ((mode_left % 8) < 5);
          end
        endcase
      end
    end
  end

  // Give up once no handshake or config write has happened for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL modbus_read_response_checker_core");
    $finish;
  end

  // Append one byte at the tail of the frame under construction
  task automatic append_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  // Lower valid, but only if it is up, so no step gets two assignments
  task automatic drop_valid();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Offer one item and hold it until taken; open a new burst after a gap
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (burst_left == 0) begin
      drop_valid();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(8, 24)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      if ($urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(30, 80);
      end else begin
        burst_left = $urandom_range(1, 8);
      end
    end
    in_valid        <= 1'b1;
    in_rx_byte      <= b;
    in_end_of_frame <= eof;
    offering = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Stop offering, wait out every expected result, then let the block settle
  task automatic drain_and_settle();
    drop_valid();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers on an idle block
  task automatic configure(input logic [7:0] addr, input logic [5:0] count);
    drain_and_settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    cfg_index <= CFG_EXPECTED_COUNT;
    cfg_data  <= {2'b00, count};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_addr  = addr;
    cur_count = count;
  endtask

  // Build one reply of the given kind against the current settings
  task automatic build_frame(input frame_kind_t kind);
    logic [7:0]  addr;
    logic [7:0]  fn;
    logic [7:0]  cnt;
    logic [15:0] crc;
    logic [15:0] w;
    int          nwords;
    int          extra;
    int          flip;
    frame_q.delete();
    addr   = cur_addr;
    fn     = FN_READ_HOLDING;
    cnt    = 8'(2 * int'(cur_count));
    nwords = int'(cur_count);
    extra  = 0;
    case (kind)
      FR_SHORT: begin
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
        return;
      end
      FR_NOISE: begin
        repeat ($urandom_range(5, 12)) append_byte(8'($urandom));
        return;
      end
      FR_ADDR: begin
        addr = addr + 8'($urandom_range(1, 255));
      end
      FR_EXC: begin
        fn     = 8'h80 | 8'($urandom_range(0, 127));
        cnt    = 8'($urandom);
        nwords = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
      end
      FR_FUNC: begin
        do fn = 8'($urandom_range(0, 127)); while (fn == FN_READ_HOLDING);
      end
      FR_BYTECOUNT: begin
        do cnt = 8'($urandom); while (cnt == 8'(2 * int'(cur_count)));
      end
      FR_LENGTH: begin
        do nwords = $urandom_range(0, int'(cur_count) + 2);
        while (nwords == int'(cur_count));
        extra = $urandom_range(0, 1);
      end
      FR_LONG: begin
        // runs the length counter into saturation and the words past the buffer
        nwords = $urandom_range(130, 150);
      end
      default: begin
      end
    endcase
    append_byte(addr);
    append_byte(fn);
    append_byte(cnt);
    repeat (nwords) begin
      case (word_pattern)
        1:       w = 16'h0000;
        2:       w = 16'hFFFF;
        default: w = 16'($urandom);
      endcase
      append_byte(w[15:8]);
      append_byte(w[7:0]);
    end
    repeat (extra) append_byte(8'($urandom));
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = crc16_fold(crc, frame_q[i]);
    append_byte(crc[7:0]);
    append_byte(crc[15:8]);
    if (kind == FR_BAD_CRC) begin
      // a single flipped bit anywhere is always caught by the CRC
      flip = $urandom_range(0, frame_q.size() - 1);
      frame_q[flip] = frame_q[flip] ^ 8'(1 << $urandom_range(0, 7));
    end
  endtask

  task automatic run_frame(input frame_kind_t kind);
    build_frame(kind);
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return FR_GOOD;
    if (r < 62) return FR_BAD_CRC;
    if (r < 68) return FR_ADDR;
    if (r < 74) return FR_EXC;
    if (r < 79) return FR_FUNC;
    if (r < 84) return FR_BYTECOUNT;
    if (r < 89) return FR_LENGTH;
    if (r < 94) return FR_SHORT;
    if (r < 99) return FR_NOISE;
    return FR_LONG;
  endfunction

  // Mostly small register counts, now and then a full buffer
  function automatic logic [5:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 6'($urandom_range(0, 4));
    if (r < 90) return 6'($urandom_range(5, 12));
    return 6'(MAX_REGS);
  endfunction

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    cur_addr  = 8'd1;
    cur_count = 6'd1;

    // Directed: reset settings, word extremes and every error kind
    word_pattern = 2;
    run_frame(FR_GOOD);
    word_pattern = 1;
    run_frame(FR_GOOD);
    word_pattern = 0;
    run_frame(FR_SHORT);
    run_frame(FR_EXC);
    run_frame(FR_ADDR);
    run_frame(FR_FUNC);
    run_frame(FR_BYTECOUNT);
    run_frame(FR_LENGTH);
    run_frame(FR_BAD_CRC);

    // Extremes of both registers
    configure(8'd0, 6'd0);
    run_frame(FR_GOOD);
    run_frame(FR_EXC);
    configure(8'd255, 6'(MAX_REGS));
    // hold the result side while a full frame and the next one arrive,
    // so the input backs up
    hold_requests <= hold_requests + 1;
    run_frame(FR_GOOD);
    run_frame(FR_SHORT);

    // Count beyond the buffer: a well-formed reply still ends in a length error
    configure(8'($urandom), 6'(MAX_REGS + 1));
    run_frame(FR_GOOD);

    // Random part: frames of every kind over changing settings
    while (bytes_sent < NUM_ITEMS) begin
      configure(8'($urandom_range(0, 255)), pick_count());
      repeat ($urandom_range(2, 6)) run_frame(pick_kind());
    end

    drain_and_settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS modbus_read_response_checker_core");
    end else begin
      $display("FAIL modbus_read_response_checker_core");
    end
    $finish;
  end

endmodule
